>>> hdl/life_like_automaton_step_top_assert.svh
// Assertion macros for the automaton step block.
// Each expects clk and rst_n in scope.
`ifndef LIFE_LIKE_AUTOMATON_STEP_TOP_ASSERT_SVH
`define LIFE_LIKE_AUTOMATON_STEP_TOP_ASSERT_SVH

`define LLA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lla: same-cycle check failed");

`define LLA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lla: next-cycle check failed");

`endif

>>> hdl/lla_pkg.sv
`default_nettype none
package lla_pkg;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } lla_state_t;

  typedef enum logic [0:0] {
    CMD_SET  = 1'b0,
    CMD_STEP = 1'b1
  } lla_cmd_t;

  localparam logic [1:0] REG_SURVIVE = 2'd0;
  localparam logic [1:0] REG_BIRTH   = 2'd1;
  localparam logic [1:0] REG_SIZE    = 2'd2;

  localparam logic [8:0] SURVIVE_RST = 9'd12;
  localparam logic [8:0] BIRTH_RST   = 9'd8;
  localparam logic [4:0] SIZE_RST    = 5'd16;

  localparam int unsigned MAX_EMIT = 16;

  typedef struct packed {
    logic shift;
    logic set;
  } lla_cell_ctl_t;

endpackage
`default_nettype wire

>>> hdl/lla_cell.sv
`default_nettype none
module lla_cell #(
  parameter int unsigned W = 16
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  lla_pkg::lla_cell_ctl_t ctl,
  input  wire  [W-1:0]         shift_in,
  input  wire  [W-1:0]         set_mask,
  output logic [W-1:0]         row_q
);
  import lla_pkg::*;

  logic [W-1:0] row_r;
  logic [W-1:0] row_nxt;

  always_comb begin
    row_nxt = row_r;
    if (ctl.shift) begin
      row_nxt = shift_in;
    end else if (ctl.set) begin
      row_nxt = row_r | set_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else begin
      row_r <= row_nxt;
    end
  end

  assign row_q = row_r;

endmodule
`default_nettype wire

>>> hdl/lla_rule.sv
`default_nettype none
module lla_rule #(
  parameter int unsigned W = 16
) (
  input  wire  [W-1:0] prev_row,
  input  wire  [W-1:0] cur_row,
  input  wire  [W-1:0] next_row,
  input  wire  [W-1:0] cur_raw,
  input  wire  [W-1:0] col_mask,
  input  wire          row_act,
  input  wire  [8:0]   survive_mask,
  input  wire  [8:0]   birth_mask,
  output logic [W-1:0] new_row
);
  import lla_pkg::*;

  logic [W+1:0] p_pad;
  logic [W+1:0] c_pad;
  logic [W+1:0] n_pad;
  logic [W-1:0] rule_row;

  assign p_pad = {1'b0, prev_row, 1'b0};
  assign c_pad = {1'b0, cur_row, 1'b0};
  assign n_pad = {1'b0, next_row, 1'b0};

  always_comb begin
    logic [3:0] cnt;
    for (int c = 0; c < W; c++) begin
      cnt = {3'b0, p_pad[c]} + {3'b0, p_pad[c+1]} + {3'b0, p_pad[c+2]}
          + {3'b0, c_pad[c]} + {3'b0, c_pad[c+2]}
          + {3'b0, n_pad[c]} + {3'b0, n_pad[c+1]} + {3'b0, n_pad[c+2]};
      rule_row[c] = (cur_row[c] & survive_mask[cnt]) | birth_mask[cnt];
    end
  end

  assign new_row = row_act ? ((rule_row & col_mask) | (cur_raw & ~col_mask)) : cur_raw;

endmodule
`default_nettype wire

>>> hdl/life_like_automaton_step_top.sv
// Life-like automaton on a bounded square grid of GRID_MAX x GRID_MAX cells,
// all dead after reset. A request with in_tuser = 0 sets the cell at
// (row, col) alive; coordinates outside the active square are dropped. A
// request with in_tuser = 1 computes one generation: the grid rows sit in a
// chain of row cells that rotates through a single rule unit by one row per
// cycle while out_tready does not stall the output, and a step emits
// min(active size, 16) rows in order with out_tlast on the final one. Cells
// outside the active square count as dead and keep their value. A new
// request is taken the cycle after a step ends.
// Registers: 0x0 survive mask, 0x4 birth mask, 0x8 active size (0 acts as 1).
`default_nettype none
module life_like_automaton_step_top #(
  parameter int unsigned GRID_MAX = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [3:0] row, [7:4] col
  input  wire  [0:0]  in_tuser,   // [0] command
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [23:0] out_tdata,  // [3:0] row_index, [19:4] row_bits, [23:20] zero
  output logic        out_tlast,
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [3:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import lla_pkg::*;

  localparam int unsigned RW = $clog2(GRID_MAX);
  localparam int unsigned NW = $clog2(GRID_MAX + 1);
  localparam int unsigned OW = (GRID_MAX < 16) ? GRID_MAX : 16;

  // configuration
  logic [8:0] survive_r;
  logic [8:0] birth_r;
  logic [4:0] size_r;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      survive_r <= SURVIVE_RST;
      birth_r   <= BIRTH_RST;
      size_r    <= SIZE_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_SURVIVE: survive_r <= cfg_pwdata[8:0];
        REG_BIRTH:   birth_r   <= cfg_pwdata[8:0];
        REG_SIZE:    size_r    <= cfg_pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_SURVIVE: cfg_prdata = {23'b0, survive_r};
      REG_BIRTH:   cfg_prdata = {23'b0, birth_r};
      REG_SIZE:    cfg_prdata = {27'b0, size_r};
      default:     cfg_prdata = '0;
    endcase
  end

  // effective size
  logic [4:0]    size_min1;
  logic [NW-1:0] n_eff;
  logic [GRID_MAX-1:0] col_mask;
  logic [31:0]   emit_cnt;

  assign size_min1 = (size_r == 5'd0) ? 5'd1 : size_r;
  assign n_eff = (32'(size_min1) > GRID_MAX) ? NW'(GRID_MAX) : NW'(size_min1);
  assign emit_cnt = (32'(n_eff) < MAX_EMIT) ? 32'(n_eff) : MAX_EMIT;

  always_comb begin
    for (int c = 0; c < GRID_MAX; c++) begin
      col_mask[c] = (32'(c) < 32'(n_eff));
    end
  end

  // control
  lla_state_t    state_r, state_nxt;
  logic [RW-1:0] r_r, r_nxt;
  logic [GRID_MAX-1:0] prev_r, prev_nxt;
  logic          in_acc, step_go, set_go;
  logic          row_act, next_act, emit_row, is_last, adv, run_done;
  logic          out_load;

  assign in_acc  = in_tvalid & in_tready;
  assign step_go = in_acc & (in_tuser[0] == CMD_STEP);
  assign set_go  = in_acc & (in_tuser[0] == CMD_SET)
                 & (32'(in_tdata[3:0]) < 32'(n_eff)) & (32'(in_tdata[7:4]) < 32'(n_eff));

  assign row_act  = (32'(r_r) < 32'(n_eff));
  assign next_act = (32'(r_r) + 32'd1 < 32'(n_eff));
  assign emit_row = row_act & (32'(r_r) < MAX_EMIT);
  assign is_last  = (32'(r_r) + 32'd1 == 32'(n_eff)) | (32'(r_r) + 32'd1 == MAX_EMIT);
  assign adv      = (state_r == ST_RUN) & (!emit_row | !out_tvalid | out_tready);
  assign run_done = adv & (32'(r_r) == GRID_MAX - 1);
  assign out_load = adv & emit_row;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (step_go) begin
        state_nxt = ST_RUN;
      end
      ST_RUN: if (run_done) begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = (state_r == ST_IDLE);
  end

  // row cell chain
  logic [GRID_MAX-1:0] row_q [GRID_MAX];
  logic [GRID_MAX-1:0] cur_m, next_m, new_row;
  logic [GRID_MAX-1:0] set_mask;

  assign set_mask = GRID_MAX'(1) << in_tdata[7:4];
  assign cur_m    = row_act ? (row_q[0] & col_mask) : '0;
  assign next_m   = next_act ? (row_q[1] & col_mask) : '0;

  always_comb begin
    r_nxt    = r_r;
    prev_nxt = prev_r;
    if (step_go) begin
      r_nxt    = '0;
      prev_nxt = '0;
    end else if (adv) begin
      r_nxt    = RW'(32'(r_r) + 32'd1);
      prev_nxt = cur_m;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      r_r     <= '0;
    end else begin
      state_r <= state_nxt;
      r_r     <= r_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r <= prev_nxt;
  end

  lla_rule #(.W(GRID_MAX)) u_rule (
    .prev_row     (prev_r),
    .cur_row      (cur_m),
    .next_row     (next_m),
    .cur_raw      (row_q[0]),
    .col_mask     (col_mask),
    .row_act      (row_act),
    .survive_mask (survive_r),
    .birth_mask   (birth_r),
    .new_row      (new_row)
  );

  for (genvar i = 0; i < GRID_MAX; i++) begin : g_cell
    lla_cell_ctl_t       ctl;
    logic [GRID_MAX-1:0] sh_in;

    assign ctl.shift = adv;
    assign ctl.set   = set_go & (32'(in_tdata[3:0]) == 32'(i));

    if (i == GRID_MAX - 1) begin : g_tail
      assign sh_in = new_row;
    end else begin : g_body
      assign sh_in = row_q[i+1];
    end

    lla_cell #(.W(GRID_MAX)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .shift_in (sh_in),
      .set_mask (set_mask),
      .row_q    (row_q[i])
    );
  end

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [3:0]  out_index_r;
  logic [15:0] out_bits_r, out_bits_nxt;
  logic        out_last_r;

  always_comb begin
    out_bits_nxt = '0;
    out_bits_nxt[OW-1:0] = new_row[OW-1:0];
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_index_r <= 4'(r_r);
      out_bits_r  <= out_bits_nxt;
      out_last_r  <= is_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_bits_r, out_index_r};
  assign out_tlast  = out_last_r;

  `include "life_like_automaton_step_top_assert.svh"

  `LLA_ASSERT_NEXT(a_step_starts, step_go, (state_r == ST_RUN) && (r_r == '0))
  `LLA_ASSERT_NEXT(a_run_ends, run_done, state_r == ST_IDLE)
  `LLA_ASSERT_NOW(a_last_row, out_tvalid && out_tlast, 32'(out_index_r) + 32'd1 == emit_cnt)

endmodule
`default_nettype wire
